FILE: sv/klt_pkg.sv
// ----------------------------------------------------------------------------
// klt_pkg
// Shared types and constants for the key event latch table.
// ----------------------------------------------------------------------------
package klt_pkg;

  localparam int CODE_W           = 31;
  localparam int SLOT_W           = 7;
  localparam int NUM_SLOTS_DEF    = 128;
  localparam int PENDING_BITS_DEF = 8;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

endpackage

FILE: sv/klt_ifs.sv
// ----------------------------------------------------------------------------
// klt_ifs
// Request and result channels of the key event latch table.
// ----------------------------------------------------------------------------
interface klt_in_if
  import klt_pkg::*;
;
  logic              valid;
  logic              ready;
  op_t               opcode;
  logic [CODE_W-1:0] key_code;
  logic              key_down;

  modport source (output valid, output opcode, output key_code, output key_down,
                  input ready);
  modport sink   (input valid, input opcode, input key_code, input key_down,
                  output ready);
endinterface

interface klt_out_if
  import klt_pkg::*;
;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [SLOT_W-1:0] slot;
  logic              clicked;
  logic              held;

  modport source (output valid, output status, output slot, output clicked,
                  output held, input ready);
  modport sink   (input valid, input status, input slot, input clicked,
                  input held, output ready);
endinterface

FILE: sv/klt_ram.sv
// ----------------------------------------------------------------------------
// klt_ram
// Slot table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module klt_ram #(
  parameter int DEPTH  = 128,
  parameter int WIDTH  = 41,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/klt_ctrl.sv
// ----------------------------------------------------------------------------
// klt_ctrl
// Request sequencer: scans the slot table, updates entries by
// read-modify-write and registers the result.
// ----------------------------------------------------------------------------
module klt_ctrl
  import klt_pkg::*;
#(
  parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
  parameter int PENDING_BITS = PENDING_BITS_DEF,
  parameter int AW           = $clog2(NUM_SLOTS),
  parameter int EW           = CODE_W + 2 + PENDING_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  klt_in_if.sink        in_ch,
  klt_out_if.source     out_ch,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [EW-1:0] wr_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [EW-1:0] rd_data
);

  typedef struct packed {
    logic [CODE_W-1:0]       code;
    logic                    held;
    logic                    clicked;
    logic [PENDING_BITS-1:0] pending;
  } entry_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_DRAIN, S_WRITE, S_DONE
  } state_t;

  localparam logic [AW-1:0] LAST = AW'(NUM_SLOTS - 1);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic              rv_r, rv_nxt;
  logic [AW-1:0]     ra_r, ra_nxt;
  op_t               op_r, op_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              down_r, down_nxt;
  logic              found_r, found_nxt;
  logic [AW-1:0]     fslot_r, fslot_nxt;
  entry_t            fent_r, fent_nxt;
  logic              free_r, free_nxt;
  logic [AW-1:0]     frslot_r, frslot_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic              res_clicked_r, res_clicked_nxt;
  logic              res_held_r, res_held_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic              out_clicked_r, out_clicked_nxt;
  logic              out_held_r, out_held_nxt;

  entry_t rd_ent;
  entry_t upd_ent;

  assign rd_ent = rd_data;

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = out_status_r;
  assign out_ch.slot    = out_slot_r;
  assign out_ch.clicked = out_clicked_r;
  assign out_ch.held    = out_held_r;

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    rv_nxt          = 1'b0;
    ra_nxt          = idx_r;
    op_nxt          = op_r;
    code_nxt        = code_r;
    down_nxt        = down_r;
    found_nxt       = found_r;
    fslot_nxt       = fslot_r;
    fent_nxt        = fent_r;
    free_nxt        = free_r;
    frslot_nxt      = frslot_r;
    res_status_nxt  = res_status_r;
    res_slot_nxt    = res_slot_r;
    res_clicked_nxt = res_clicked_r;
    res_held_nxt    = res_held_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_clicked_nxt = out_clicked_r;
    out_held_nxt    = out_held_r;
    rd_en           = 1'b0;
    rd_addr         = idx_r;
    wr_en           = 1'b0;
    wr_addr         = ra_r;
    upd_ent         = rd_ent;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Handle the entry read in the previous cycle; its write-back lands one
    // address behind the read, so the two never collide.
    if (rv_r) begin
      case (op_r)
        OP_TICK: begin
          wr_en = 1'b1;
          if (rd_ent.pending != '0) begin
            upd_ent.pending = rd_ent.pending - 1'b1;
            upd_ent.clicked = 1'b1;
          end else begin
            upd_ent.clicked = 1'b0;
          end
        end
        OP_CLEAR: begin
          wr_en        = 1'b1;
          upd_ent.held = 1'b0;
        end
        default: begin
          if (!found_r && rd_ent.code == code_r) begin
            found_nxt = 1'b1;
            fslot_nxt = ra_r;
            fent_nxt  = rd_ent;
          end
          // Ascending scan: keep the last empty slot seen.
          if (rd_ent.code == '0) begin
            free_nxt   = 1'b1;
            frslot_nxt = ra_r;
          end
        end
      endcase
    end

    case (state_r)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        upd_ent = '0;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt          = in_ch.opcode;
          code_nxt        = in_ch.key_code;
          down_nxt        = in_ch.key_down;
          found_nxt       = 1'b0;
          free_nxt        = 1'b0;
          idx_nxt         = '0;
          res_status_nxt  = ST_OK;
          res_slot_nxt    = '0;
          res_clicked_nxt = 1'b0;
          res_held_nxt    = 1'b0;
          if ((in_ch.opcode == OP_KEY || in_ch.opcode == OP_QUERY) &&
              in_ch.key_code == '0) begin
            res_status_nxt = ST_INVALID;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_en   = 1'b1;
        rv_nxt  = 1'b1;
        ra_nxt  = idx_r;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST) begin
          idx_nxt   = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        case (op_r)
          OP_KEY: begin
            if (found_r) begin
              wr_en        = 1'b1;
              wr_addr      = fslot_r;
              upd_ent      = fent_r;
              res_slot_nxt = SLOT_W'(fslot_r);
            end else if (free_r) begin
              // An empty slot holds an all-zero entry.
              wr_en        = 1'b1;
              wr_addr      = frslot_r;
              upd_ent      = '0;
              upd_ent.code = code_r;
              res_slot_nxt = SLOT_W'(frslot_r);
            end else begin
              res_status_nxt = ST_FULL;
            end
            upd_ent.held = down_r;
            if (down_r && upd_ent.pending != '1) begin
              upd_ent.pending = upd_ent.pending + 1'b1;
            end
          end
          OP_QUERY: begin
            if (found_r) begin
              res_slot_nxt    = SLOT_W'(fslot_r);
              res_clicked_nxt = fent_r.clicked;
              res_held_nxt    = fent_r.held;
            end else begin
              res_status_nxt = ST_NOT_FOUND;
            end
          end
          default: ;
        endcase
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_slot_nxt    = res_slot_r;
          out_clicked_nxt = res_clicked_r;
          out_held_nxt    = res_held_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    wr_data = upd_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      idx_r       <= '0;
      rv_r        <= 1'b0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      rv_r        <= rv_nxt;
      found_r     <= found_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ra_r          <= ra_nxt;
    op_r          <= op_nxt;
    code_r        <= code_nxt;
    down_r        <= down_nxt;
    fslot_r       <= fslot_nxt;
    fent_r        <= fent_nxt;
    frslot_r      <= frslot_nxt;
    res_status_r  <= res_status_nxt;
    res_slot_r    <= res_slot_nxt;
    res_clicked_r <= res_clicked_nxt;
    res_held_r    <= res_held_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_clicked_r <= out_clicked_nxt;
    out_held_r    <= out_held_nxt;
  end

`ifndef NO_ASSERTIONS
  a_no_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write hit the same slot in one cycle");

  a_found_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE && found_r) |-> (fent_r.code == code_r))
    else $error("found slot does not hold the requested code");

  a_no_req_during_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> !in_ch.ready)
    else $error("request taken during the clearing pass");

  a_scan_writeback: assert property (@(posedge clk) disable iff (!rst_n)
    (rv_r && (op_r == OP_TICK || op_r == OP_CLEAR)) |-> (wr_en && wr_addr == ra_r))
    else $error("scan entry not written back");
`endif

endmodule

FILE: sv/key_event_latch_table.sv
// ----------------------------------------------------------------------------
// key_event_latch_table
// Key code table with per-key press latching, built around one slot RAM.
//
//   channel  | dir | handshake    | payload
//   in_ch    | in  | valid/ready  | opcode, key_code, key_down
//   out_ch   | out | valid/ready  | status, slot, clicked, held
//
// Each request except a zero-code event or query scans every slot through
// the RAM read port before its result is registered. Zero-code events and
// queries return ST_INVALID without a scan. One request is in flight at a
// time. After reset a clearing pass over every slot zeroes the RAM; no
// request is taken meanwhile. A stalled result holds in the output register;
// the next request may be taken while it waits.
// ----------------------------------------------------------------------------
module key_event_latch_table
  import klt_pkg::*;
#(
  parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
  parameter int PENDING_BITS = PENDING_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  klt_in_if.sink    in_ch,
  klt_out_if.source out_ch
);

  localparam int AW = $clog2(NUM_SLOTS);
  localparam int EW = CODE_W + 2 + PENDING_BITS;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;

  klt_ctrl #(
    .NUM_SLOTS    (NUM_SLOTS),
    .PENDING_BITS (PENDING_BITS),
    .AW           (AW),
    .EW           (EW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  klt_ram #(
    .DEPTH  (NUM_SLOTS),
    .WIDTH  (EW),
    .ADDR_W (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
